// ===== src/vrp_pkg.sv =====
// shared types and codes for the video register port and frame timing block
package vrp_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_req;
    logic [7:0] wdata;
    logic       silent;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       nmi_pulse;
  } result_t;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_VADDR    = 3'd6;
  localparam logic [2:0] REG_VDATA    = 3'd7;

  localparam logic [7:0]  VBLANK_BIT   = 8'h80;
  localparam logic [7:0]  VBLANK_CLEAR = 8'h7F;
  localparam logic [7:0]  CTRL_NT_MASK = 8'hFC;
  localparam logic [15:0] VADDR_STEP_ROW = 16'h0020;
  localparam logic [15:0] VADDR_STEP_COL = 16'h0001;
  localparam logic [7:0]  PAL_PAGE     = 8'h3F;

  localparam int VBLANK_START_LINE = 240;
  localparam int VBLANK_END_LINE   = 260;

  localparam int VRAM_DEPTH = 2048;
  localparam int VRAM_AW    = 11;
  localparam int SPR_DEPTH  = 256;
  localparam int SPR_AW     = 8;
  localparam int PAL_DEPTH  = 32;
  localparam int PAL_AW     = 5;

endpackage

// ===== src/video_register_port_and_frame_timing.sv =====
// video register port and frame timing: cpu register accesses, dot ticks, video memories
//
// one input channel: an item (register read, register write or one dot tick) is taken
// at a rising edge with start high and busy low. every item gives exactly one result
// word on result, marked by strobe for a single cycle; the receiver cannot stall it.
// the item is registered at the accept edge, its work is done in the next cycle against
// the registered memory read data, and the result word is registered at the same edge
// as strobe, so the word is valid while strobe is high.
// throughput: one item per cycle while busy is low. the nametable ram and sprite table
// are read ahead at the address the state holds after the previous item, with a bypass
// for a write landing at the same edge, so back-to-back data port accesses never wait.
// reset: state registers, strobe and palette clear at once (not item_q or result); then
// a clearing pass writes zero through the 2048-entry nametable ram (and the 256-entry
// sprite table in the same sweep), one entry per cycle with busy high, taking no item.
// after that busy stays low. frames are LINE_DOTS x FRAME_LINES dots, every other one
// a dot shorter; vblank is set at dot 240*LINE_DOTS+1, raising nmi_pulse if interrupts
// are enabled, and cleared at dot 260*LINE_DOTS+1.
module video_register_port_and_frame_timing #(
  parameter int LINE_DOTS   = 341,
  parameter int FRAME_LINES = 262
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  vrp_pkg::item_t  item,
  output logic            strobe,
  output vrp_pkg::result_t result
);

  localparam int TOTAL_DOTS = LINE_DOTS * FRAME_LINES;
  localparam int DOT_W      = $clog2(TOTAL_DOTS);
  localparam logic [DOT_W-1:0] LAST_DOT  = DOT_W'(TOTAL_DOTS - 1);
  localparam logic [DOT_W-1:0] VBL_SET   =
    DOT_W'(vrp_pkg::VBLANK_START_LINE * LINE_DOTS + 1);
  localparam logic [DOT_W-1:0] VBL_CLEAR =
    DOT_W'(vrp_pkg::VBLANK_END_LINE * LINE_DOTS + 1);

  // memories
  logic [7:0] video_ram    [vrp_pkg::VRAM_DEPTH];
  logic [7:0] sprite_table [vrp_pkg::SPR_DEPTH];
  logic [7:0] palette_ram  [vrp_pkg::PAL_DEPTH];

  // clearing pass
  logic                        clearing;
  logic [vrp_pkg::VRAM_AW-1:0] clr_cnt;

  // input stage
  vrp_pkg::item_t item_q;
  logic           item_v;

  // state
  logic [15:0]      video_address, video_address_next;
  logic [7:0]       read_buffer, read_buffer_next;
  logic [7:0]       sprite_address, sprite_address_next;
  logic [7:0]       status_bits, status_bits_next;
  logic [7:0]       control_bits, control_bits_next;
  logic [7:0]       mask_bits, mask_bits_next;
  logic [7:0]       scroll_x, scroll_x_next;
  logic [7:0]       scroll_y, scroll_y_next;
  logic             scroll_toggle, scroll_toggle_next;
  logic [DOT_W-1:0] dot_counter, dot_counter_next;
  logic             odd_frame, odd_frame_next;

  // memory ports
  logic                        vram_we;
  logic [vrp_pkg::VRAM_AW-1:0] vram_waddr, vram_raddr;
  logic [7:0]                  vram_rdata;
  logic                        spr_we;
  logic [vrp_pkg::SPR_AW-1:0]  spr_waddr, spr_raddr;
  logic [7:0]                  spr_rdata;
  logic [7:0]                  mem_wdata;
  logic                        pal_we;
  logic [vrp_pkg::PAL_AW-1:0]  pal_idx;

  vrp_pkg::result_t res_next;

  logic        nt_hit, pal_hit;
  logic [7:0]  vdata_val;
  logic [15:0] vaddr_step;
  logic [DOT_W-1:0] nd;

  assign busy = clearing;

  // address decode of the current video address
  assign nt_hit  = (video_address[15:13] == 3'b001) && !video_address[11];
  assign pal_hit = (video_address[15:8] == vrp_pkg::PAL_PAGE);
  // entries 0x10/14/18/1c alias down onto 0x00/04/08/0c
  assign pal_idx = {video_address[4] && (video_address[1:0] != 2'b00),
                    video_address[3:0]};
  assign vaddr_step = control_bits[2] ? vrp_pkg::VADDR_STEP_ROW : vrp_pkg::VADDR_STEP_COL;

  always_comb begin
    unique if (nt_hit) begin
      vdata_val = vram_rdata;
    end else if (pal_hit) begin
      vdata_val = palette_ram[pal_idx];
    end else begin
      vdata_val = 8'h00;
    end
  end

  always_comb begin
    if (dot_counter == LAST_DOT) begin
      nd = odd_frame ? '0 : DOT_W'(1);
    end else begin
      nd = dot_counter + DOT_W'(1);
    end
  end

  always_comb begin
    video_address_next  = video_address;
    read_buffer_next    = read_buffer;
    sprite_address_next = sprite_address;
    status_bits_next    = status_bits;
    control_bits_next   = control_bits;
    mask_bits_next      = mask_bits;
    scroll_x_next       = scroll_x;
    scroll_y_next       = scroll_y;
    scroll_toggle_next  = scroll_toggle;
    dot_counter_next    = dot_counter;
    odd_frame_next      = odd_frame;
    res_next            = '0;
    vram_we             = 1'b0;
    vram_waddr          = video_address[vrp_pkg::VRAM_AW-1:0];
    spr_we              = 1'b0;
    spr_waddr           = sprite_address;
    mem_wdata           = item_q.wdata;
    pal_we              = 1'b0;

    if (clearing) begin
      vram_we    = 1'b1;
      vram_waddr = clr_cnt;
      spr_we     = 1'b1;
      spr_waddr  = clr_cnt[vrp_pkg::SPR_AW-1:0];
      mem_wdata  = 8'h00;
    end else if (item_v) begin
      unique case (item_q.kind)
        vrp_pkg::KIND_READ: begin
          unique case (item_q.reg_req)
            vrp_pkg::REG_STATUS: begin
              res_next.rdata = status_bits;
              if (!item_q.silent) begin
                status_bits_next = status_bits & vrp_pkg::VBLANK_CLEAR;
                read_buffer_next = 8'h00;
                scroll_x_next    = 8'h00;
                scroll_y_next    = 8'h00;
              end
            end
            vrp_pkg::REG_SPR_DATA: res_next.rdata = spr_rdata;
            vrp_pkg::REG_VDATA: begin
              if (item_q.silent) begin
                res_next.rdata = read_buffer;
              end else begin
                // palette reads bypass the one-byte delay
                res_next.rdata     = pal_hit ? vdata_val : read_buffer;
                read_buffer_next   = vdata_val;
                video_address_next = video_address + vaddr_step;
              end
            end
            default: ;
          endcase
        end
        vrp_pkg::KIND_WRITE: begin
          unique case (item_q.reg_req)
            vrp_pkg::REG_CTRL:     control_bits_next   = item_q.wdata;
            vrp_pkg::REG_MASK:     mask_bits_next      = item_q.wdata;
            vrp_pkg::REG_SPR_ADDR: sprite_address_next = item_q.wdata;
            vrp_pkg::REG_SPR_DATA: begin
              spr_we              = 1'b1;
              sprite_address_next = sprite_address + 8'd1;
            end
            vrp_pkg::REG_SCROLL: begin
              if (scroll_toggle) begin
                scroll_y_next = item_q.wdata;
              end else begin
                scroll_x_next = item_q.wdata;
              end
              scroll_toggle_next = !scroll_toggle;
            end
            vrp_pkg::REG_VADDR: video_address_next = {video_address[7:0], item_q.wdata};
            vrp_pkg::REG_VDATA: begin
              vram_we            = nt_hit;
              pal_we             = pal_hit;
              video_address_next = video_address + vaddr_step;
            end
            default: ;
          endcase
        end
        vrp_pkg::KIND_TICK: begin
          if (dot_counter == LAST_DOT) begin
            control_bits_next = control_bits & vrp_pkg::CTRL_NT_MASK;
            odd_frame_next    = !odd_frame;
          end
          if (nd == VBL_SET) begin
            status_bits_next   = status_bits | vrp_pkg::VBLANK_BIT;
            res_next.nmi_pulse = control_bits[7];
          end
          if (nd == VBL_CLEAR) begin
            status_bits_next = 8'h00;
          end
          dot_counter_next = nd;
        end
        default: ;
      endcase
    end
  end

  // read ahead at the address the next item will see
  assign vram_raddr = video_address_next[vrp_pkg::VRAM_AW-1:0];
  assign spr_raddr  = sprite_address_next;

  always_ff @(posedge clk) begin
    if (vram_we) begin
      video_ram[vram_waddr] <= mem_wdata;
    end
    if (vram_we && (vram_waddr == vram_raddr)) begin
      vram_rdata <= mem_wdata;
    end else begin
      vram_rdata <= video_ram[vram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (spr_we) begin
      sprite_table[spr_waddr] <= mem_wdata;
    end
    if (spr_we && (spr_waddr == spr_raddr)) begin
      spr_rdata <= mem_wdata;
    end else begin
      spr_rdata <= sprite_table[spr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vrp_pkg::PAL_DEPTH; i++) begin
        palette_ram[i] <= 8'h00;
      end
    end else if (pal_we) begin
      palette_ram[pal_idx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_q <= item;
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v         <= 1'b0;
      strobe         <= 1'b0;
      video_address  <= '0;
      read_buffer    <= '0;
      sprite_address <= '0;
      status_bits    <= '0;
      control_bits   <= '0;
      mask_bits      <= '0;
      scroll_x       <= '0;
      scroll_y       <= '0;
      scroll_toggle  <= 1'b0;
      dot_counter    <= '0;
      odd_frame      <= 1'b0;
    end else begin
      item_v         <= start && !busy;
      strobe         <= item_v && !clearing;
      video_address  <= video_address_next;
      read_buffer    <= read_buffer_next;
      sprite_address <= sprite_address_next;
      status_bits    <= status_bits_next;
      control_bits   <= control_bits_next;
      mask_bits      <= mask_bits_next;
      scroll_x       <= scroll_x_next;
      scroll_y       <= scroll_y_next;
      scroll_toggle  <= scroll_toggle_next;
      dot_counter    <= dot_counter_next;
      odd_frame      <= odd_frame_next;
    end
  end

endmodule
